[rtl/m3i_pkg.sv]
`default_nettype none

package m3i_pkg;

   localparam int THR_WIDTH = 31;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd7;

   // Pipeline stages from the cofactor registers to the determinant magnitude.
   localparam int DET_LAT = 4;

   // Element indexes (row * 3 + column) of the two products that form each
   // cofactor: cof = a[P] * a[Q] - a[R] * a[S], listed in transposed order.
   localparam int COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

[rtl/matrix3x3_inverse.sv]
`default_nettype none

// Inverts one 3x3 matrix of signed fixed-point elements per clock, while the
// result side does not stall, by the adjugate: nine cofactor lanes form the
// cofactors exactly, a shared unit forms the exact determinant and the
// singular test, and nine divider lanes each produce one rounded, saturated
// inverse element; the divider lanes resolve one quotient bit per stage. A
// new word is taken every cycle unless req_stall is set. When the result side
// stalls, the whole pipeline holds. A matrix whose determinant magnitude is
// at or below the threshold register gives all-zero elements with singular
// set.
module matrix3x3_inverse #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r0c0,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r0c1,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r0c2,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r1c0,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r1c1,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r1c2,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r2c0,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r2c1,
   input  wire logic signed [ELEM_WIDTH-1:0]        req_in_r2c2,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r0c0,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r0c1,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r0c2,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r1c0,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r1c1,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r1c2,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r2c0,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r2c1,
   output logic signed [ELEM_WIDTH-1:0]             rsp_out_r2c2,
   output logic                                     rsp_singular,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [m3i_pkg::THR_WIDTH-1:0]       csr_singular_threshold
);

   localparam int EW = ELEM_WIDTH;
   localparam int DW = 3 * EW + 3;
   localparam int STAGES = EW + 9;

   logic [STAGES-1:0]                   v_ff;
   logic                                en;
   logic [m3i_pkg::THR_WIDTH-1:0]       thr_ff;
   logic signed [EW-1:0]                elem [9];
   logic signed [2*EW:0]                cof [9];
   logic [DW-1:0]                       det_abs;
   logic                                det_neg;
   logic                                det_sing;
   logic                                sing_ff [EW+2];
   logic [EW-1:0]                       quo [9];
   logic                                ovf [9];
   logic                                neg [9];
   logic signed [EW-1:0]                res_in [9];
   logic signed [EW-1:0]                out_ff [9];
   logic                                out_sing_ff;

   assign en        = !(v_ff[STAGES-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = v_ff[STAGES-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         thr_ff <= m3i_pkg::THR_RESET;
      end else begin
         if (en) begin
            v_ff <= {v_ff[STAGES-2:0], req_valid};
         end
         if (csr_valid) begin
            thr_ff <= csr_singular_threshold;
         end
      end
   end

   assign elem[0] = req_in_r0c0;
   assign elem[1] = req_in_r0c1;
   assign elem[2] = req_in_r0c2;
   assign elem[3] = req_in_r1c0;
   assign elem[4] = req_in_r1c1;
   assign elem[5] = req_in_r1c2;
   assign elem[6] = req_in_r2c0;
   assign elem[7] = req_in_r2c1;
   assign elem[8] = req_in_r2c2;

   for (genvar k = 0; k < 9; k++) begin : g_cof
      m3i_cof_lane #(
         .EW (EW)
      ) u_cof (
         .clock (clock),
         .en    (en),
         .p     (elem[m3i_pkg::COF_P[k]]),
         .q     (elem[m3i_pkg::COF_Q[k]]),
         .r     (elem[m3i_pkg::COF_R[k]]),
         .s     (elem[m3i_pkg::COF_S[k]]),
         .cof   (cof[k])
      );
   end

   m3i_det #(
      .EW (EW),
      .FB (FRAC_BITS)
   ) u_det (
      .clock    (clock),
      .en       (en),
      .a0       (elem[0]),
      .a1       (elem[1]),
      .a2       (elem[2]),
      .c0       (cof[0]),
      .c3       (cof[3]),
      .c6       (cof[6]),
      .thr      (thr_ff),
      .det_abs  (det_abs),
      .det_neg  (det_neg),
      .singular (det_sing)
   );

   for (genvar k = 0; k < 9; k++) begin : g_div
      logic [EW-1:0] lim_in;
      logic [EW-1:0] mag_in;

      m3i_div_lane #(
         .EW (EW),
         .FB (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .cof     (cof[k]),
         .det_abs (det_abs),
         .det_neg (det_neg),
         .quo     (quo[k]),
         .ovf     (ovf[k]),
         .neg     (neg[k])
      );

      always_comb begin
         lim_in    = neg[k] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
         mag_in    = (ovf[k] || (quo[k] > lim_in)) ? lim_in : quo[k];
         res_in[k] = neg[k] ? $signed(-mag_in) : $signed(mag_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= det_sing;
         for (int i = 1; i < EW + 2; i++) begin
            sing_ff[i] <= sing_ff[i-1];
         end
         for (int k = 0; k < 9; k++) begin
            out_ff[k] <= sing_ff[EW+1] ? '0 : res_in[k];
         end
         out_sing_ff <= sing_ff[EW+1];
      end
   end

   assign rsp_out_r0c0 = out_ff[0];
   assign rsp_out_r0c1 = out_ff[1];
   assign rsp_out_r0c2 = out_ff[2];
   assign rsp_out_r1c0 = out_ff[3];
   assign rsp_out_r1c1 = out_ff[4];
   assign rsp_out_r1c2 = out_ff[5];
   assign rsp_out_r2c0 = out_ff[6];
   assign rsp_out_r2c1 = out_ff[7];
   assign rsp_out_r2c2 = out_ff[8];
   assign rsp_singular = out_sing_ff;

endmodule

`default_nettype wire

[rtl/m3i_cof_lane.sv]
`default_nettype none

module m3i_cof_lane #(
   parameter int EW = 32
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [EW-1:0]  p,
   input  wire logic signed [EW-1:0]  q,
   input  wire logic signed [EW-1:0]  r,
   input  wire logic signed [EW-1:0]  s,
   output logic signed [2*EW:0]       cof
);

   logic signed [2*EW-1:0] pq_ff;
   logic signed [2*EW-1:0] rs_ff;
   logic signed [2*EW:0]   cof_ff;
   logic signed [2*EW:0]   cof_in;

   assign cof_in = (2*EW+1)'(pq_ff) - (2*EW+1)'(rs_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pq_ff  <= p * q;
         rs_ff  <= r * s;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

`default_nettype wire

[rtl/m3i_det.sv]
`default_nettype none

module m3i_det #(
   parameter int EW = 32,
   parameter int FB = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [EW-1:0]                 a0,
   input  wire logic signed [EW-1:0]                 a1,
   input  wire logic signed [EW-1:0]                 a2,
   input  wire logic signed [2*EW:0]                 c0,
   input  wire logic signed [2*EW:0]                 c3,
   input  wire logic signed [2*EW:0]                 c6,
   input  wire logic [m3i_pkg::THR_WIDTH-1:0]        thr,
   output logic [3*EW+2:0]                           det_abs,
   output logic                                      det_neg,
   output logic                                      singular
);

   localparam int CW = 2 * EW + 1;
   localparam int TW = 3 * EW + 1;
   localparam int DW = 3 * EW + 3;
   localparam int BTW = m3i_pkg::THR_WIDTH + 2 * FB;
   localparam int BW = (BTW > DW) ? BTW : DW;

   logic signed [EW-1:0]  a_d1_ff [3];
   logic signed [EW-1:0]  a_d2_ff [3];
   logic signed [CW-1:0]  cof [3];
   logic signed [2*EW:0]  pl_ff [3];
   logic signed [2*EW:0]  ph_ff [3];
   logic signed [TW-1:0]  term_ff [3];
   logic signed [DW-1:0]  det_ff;
   logic [DW-1:0]         abs_in;
   logic [BW-1:0]         bound_in;
   logic [DW-1:0]         abs_ff;
   logic                  neg_ff;
   logic                  sing_ff;

   assign cof[0] = c0;
   assign cof[1] = c3;
   assign cof[2] = c6;

   always_ff @(posedge clock) begin
      if (en) begin
         a_d1_ff[0] <= a0;
         a_d1_ff[1] <= a1;
         a_d1_ff[2] <= a2;
         for (int j = 0; j < 3; j++) begin
            a_d2_ff[j] <= a_d1_ff[j];
            pl_ff[j]   <= a_d2_ff[j] * $signed({1'b0, cof[j][EW-1:0]});
            ph_ff[j]   <= a_d2_ff[j] * $signed(cof[j][CW-1:EW]);
            term_ff[j] <= (TW'(ph_ff[j]) <<< EW) + TW'(pl_ff[j]);
         end
         det_ff  <= DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
         abs_ff  <= abs_in;
         neg_ff  <= det_ff[DW-1];
         sing_ff <= BW'(abs_in) <= bound_in;
      end
   end

   assign abs_in   = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   assign bound_in = BW'(thr) << (2 * FB);

   assign det_abs  = abs_ff;
   assign det_neg  = neg_ff;
   assign singular = sing_ff;

endmodule

`default_nettype wire

[rtl/m3i_div_lane.sv]
`default_nettype none

module m3i_div_lane #(
   parameter int EW = 32,
   parameter int FB = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic signed [2*EW:0]  cof,
   input  wire logic [3*EW+2:0]       det_abs,
   input  wire logic                  det_neg,
   output logic [EW-1:0]              quo,
   output logic                       ovf,
   output logic                       neg
);

   localparam int CW = 2 * EW + 1;
   localparam int DW = 3 * EW + 3;
   localparam int SW = CW + 2 * FB + 1;
   localparam int NW = ((SW > DW) ? SW : DW) + 1;
   localparam int HW = NW - EW;
   localparam int XW = (HW > DW + 1) ? HW : DW + 1;
   localparam int LAT = m3i_pkg::DET_LAT;

   logic signed [CW-1:0] cof_dly_ff [LAT];
   logic signed [CW-1:0] cof_last;
   logic [CW-1:0]        cof_abs_in;
   logic [NW-1:0]        n_in;
   logic [NW-1:0]        n_ff;
   logic [DW:0]          d_ff;
   logic                 neg_ff;
   logic [XW-1:0]        nh_in;

   logic [DW:0]    rem_ff [EW+1];
   logic [EW-1:0]  nlo_ff [EW+1];
   logic [EW-1:0]  q_ff [EW+1];
   logic [DW:0]    dd_ff [EW+1];
   logic           ovf_ff [EW+1];
   logic           sg_ff [EW+1];

   assign cof_last   = cof_dly_ff[LAT-1];
   assign cof_abs_in = cof_last[CW-1] ? CW'(-cof_last) : CW'(cof_last);
   assign n_in       = (NW'(cof_abs_in) << (2 * FB + 1)) + NW'(det_abs);
   assign nh_in      = XW'(n_ff >> EW);

   always_ff @(posedge clock) begin
      if (en) begin
         cof_dly_ff[0] <= cof;
         for (int i = 1; i < LAT; i++) begin
            cof_dly_ff[i] <= cof_dly_ff[i-1];
         end
         n_ff   <= n_in;
         d_ff   <= (DW+1)'(det_abs) << 1;
         neg_ff <= cof_last[CW-1] ^ det_neg;

         rem_ff[0] <= (DW+1)'(nh_in);
         nlo_ff[0] <= n_ff[EW-1:0];
         q_ff[0]   <= '0;
         dd_ff[0]  <= d_ff;
         ovf_ff[0] <= nh_in >= XW'(d_ff);
         sg_ff[0]  <= neg_ff;
      end
   end

   for (genvar i = 0; i < EW; i++) begin : g_bit
      logic [DW+1:0] t_in;
      logic [DW+1:0] diff_in;
      logic          ge_in;
      logic [EW-1:0] q_in;

      always_comb begin
         t_in    = {rem_ff[i], nlo_ff[i][EW-1-i]};
         diff_in = t_in - {1'b0, dd_ff[i]};
         ge_in   = t_in >= {1'b0, dd_ff[i]};
         q_in    = q_ff[i];
         q_in[EW-1-i] = ge_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge_in ? diff_in[DW:0] : t_in[DW:0];
            nlo_ff[i+1] <= nlo_ff[i];
            q_ff[i+1]   <= q_in;
            dd_ff[i+1]  <= dd_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            sg_ff[i+1]  <= sg_ff[i];
         end
      end
   end

   assign quo = q_ff[EW];
   assign ovf = ovf_ff[EW];
   assign neg = sg_ff[EW];

endmodule

`default_nettype wire

[bench/inverse_checker.sv]
`timescale 1ns / 100ps

module inverse_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic signed [31:0] req_elem [9],
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [31:0] rsp_elem [9],
   input  wire logic               rsp_singular,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [30:0]        csr_singular_threshold,
   output int                      fail_count,
   output int                      pending
);

   typedef struct {
      logic signed [31:0] elem [9];
      logic               singular;
   } inverse_type;

   localparam int P_IDX [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int Q_IDX [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int R_IDX [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int S_IDX [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic [30:0] threshold;
   inverse_type expected_inverses [$];

   function automatic logic signed [31:0] round_divide(logic signed [127:0] cof,
                                                       logic signed [127:0] det);
      logic         neg;
      logic [255:0] num, den, quo, lim;
      neg = cof[127] ^ det[127];
      num = 256'(cof[127] ? -cof : cof) << 32;
      den = 256'(det[127] ? -det : det);
      quo = (2 * num + den) / (2 * den);
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (quo > lim) begin
         quo = lim;
      end
      return neg ? -quo[31:0] : quo[31:0];
   endfunction

   function automatic inverse_type invert(logic signed [31:0] a [9], logic [30:0] thr);
      inverse_type         res;
      logic signed [127:0] cof [9];
      logic signed [127:0] det, mag;
      for (int i = 0; i < 9; i++) begin
         cof[i] = 128'(a[P_IDX[i]]) * 128'(a[Q_IDX[i]])
                - 128'(a[R_IDX[i]]) * 128'(a[S_IDX[i]]);
      end
      det = 128'(a[0]) * cof[0] + 128'(a[1]) * cof[3] + 128'(a[2]) * cof[6];
      mag = det[127] ? -det : det;
      res.singular = (det == 0) || (mag <= (128'(thr) << 32));
      for (int i = 0; i < 9; i++) begin
         res.elem[i] = res.singular ? 32'sd0 : round_divide(cof[i], det);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      inverse_type exp_inv;
      if (reset) begin
         threshold <= 31'd7;
         fail_count = 0;
         expected_inverses.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_inverses.push_back(invert(req_elem, threshold));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Unexpected result word at %0t", $realtime);
               end
            end else begin
               exp_inv = expected_inverses.pop_front();
               for (int i = 0; i < 10; i++) begin
                  if ((i < 9 && rsp_elem[i] !== exp_inv.elem[i])
                      || (i == 9 && rsp_singular !== exp_inv.singular)) begin
                     fail_count++;
                     if (fail_count <= 10) begin
                        if (i < 9) begin
                           $display("Element %0d: expected %h, got %h", i,
                                    exp_inv.elem[i], rsp_elem[i]);
                        end else begin
                           $display("Singular: expected %b, got %b",
                                    exp_inv.singular, rsp_singular);
                        end
                     end
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            threshold <= csr_singular_threshold;
         end
      end
      pending = expected_inverses.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_elem [9];
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [31:0] rsp_elem [9];
   logic               rsp_singular;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [30:0]        csr_singular_threshold = 31'd0;
   int                 fail_count;
   int                 pending;
   int                 idle_cycles;

   initial begin
      for (int i = 0; i < 9; i++) begin
         req_elem[i] = 32'sd0;
      end
   end

   always #5 clock = ~clock;

   matrix3x3_inverse dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_in_r0c0(req_elem[0]), .req_in_r0c1(req_elem[1]), .req_in_r0c2(req_elem[2]),
      .req_in_r1c0(req_elem[3]), .req_in_r1c1(req_elem[4]), .req_in_r1c2(req_elem[5]),
      .req_in_r2c0(req_elem[6]), .req_in_r2c1(req_elem[7]), .req_in_r2c2(req_elem[8]),
      .rsp_valid, .rsp_stall,
      .rsp_out_r0c0(rsp_elem[0]), .rsp_out_r0c1(rsp_elem[1]), .rsp_out_r0c2(rsp_elem[2]),
      .rsp_out_r1c0(rsp_elem[3]), .rsp_out_r1c1(rsp_elem[4]), .rsp_out_r1c2(rsp_elem[5]),
      .rsp_out_r2c0(rsp_elem[6]), .rsp_out_r2c1(rsp_elem[7]), .rsp_out_r2c2(rsp_elem[8]),
      .rsp_singular, .csr_valid, .csr_ready, .csr_singular_threshold
   );

   inverse_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_elem, .rsp_valid, .rsp_stall,
      .rsp_elem, .rsp_singular, .csr_valid, .csr_ready, .csr_singular_threshold,
      .fail_count, .pending
   );

   function automatic logic signed [31:0] pick_elem(int mode);
      case (mode)
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0001_0000 * $signed(32'($urandom_range(0, 8)) - 4);
         3: return $signed(32'($urandom_range(0, 16'hFFFF))) - 32'sh8000;
         4: return $signed($urandom()) >>> $urandom_range(0, 31);
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send_word(input logic signed [31:0] m [9]);
      int gap;
      gap = $urandom_range(0, 17) * $urandom_range(0, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) begin
         req_elem[i] <= m[i];
      end
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_threshold(input logic [30:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_singular_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      logic signed [31:0] m [9];
      int                 mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 5);
         for (int i = 0; i < 9; i++) begin
            m[i] = pick_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 5) : mode);
         end
         if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < 3; i++) begin
               m[6 + i] = m[3 + i];
            end
         end
         send_word(m);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall || idle_cycles <= 0) begin
            rsp_stall <= ($urandom_range(0, 2) != 0) ? 1'b0 : 1'b1;
            idle_cycles <= $urandom_range(0, 17);
         end else if (rsp_stall) begin
            idle_cycles <= idle_cycles - 1;
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 2000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] m [9];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_threshold(31'd7);
      for (int k = 0; k < 20; k++) begin
         for (int i = 0; i < 9; i++) begin
            m[i] = (k < 6) ? pick_elem(k) : (i % 4 == 0 ? pick_elem(2) : 32'sd0);
         end
         if (k == 6) begin
            m[0] = 32'sh0001_0000; m[4] = 32'sh0001_0000; m[8] = 32'sh0001_0000;
         end
         if (k == 7) begin
            m = '{32'sh10, 0, 0, 0, 32'sh10, 0, 0, 0, 32'sh10};
         end
         if (k == 8) begin
            m = '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100};
         end
         send_word(m);
      end
      write_threshold(31'd0);
      send_word('{32'sh10, 0, 0, 0, 32'sh10, 0, 0, 0, 32'sh10});
      send_word('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_word('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_random(250);
      write_threshold(31'h7FFF_FFFF);
      send_random(150);
      write_threshold(31'($urandom()));
      send_random(200);
      write_threshold(31'd7);
      send_random(280);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
